/* sv/hmr_pkg.sv */
`default_nettype none

package hmr_pkg;

  localparam int unsigned CHAN_W = 32;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CNT_W  = 11;
  localparam int unsigned SEQ_W  = 7;
  localparam int unsigned TICK_W = 32;

  // Bit of the command byte that marks an init packet
  localparam int unsigned INIT_FLAG_BIT = 7;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd3000;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_STARTED   = 3'd1,
    ST_CONTINUED = 3'd2,
    ST_COMPLETE  = 3'd3,
    ST_TIMEOUT   = 3'd4,
    ST_BUSY      = 3'd5,
    ST_INV_CMD   = 3'd6,
    ST_INV_SEQ   = 3'd7
  } status_t;

  typedef struct packed {
    logic              opcode;
    logic [CHAN_W-1:0] packet_chan;
    logic [CMD_W-1:0]  cmd_or_seq;
    logic [LEN_W-1:0]  byte_count;
  } in_req_t;

  typedef struct packed {
    status_t           status;
    logic [CHAN_W-1:0] active_channel;
    logic [CMD_W-1:0]  message_command;
    logic [LEN_W-1:0]  message_length;
    logic [CNT_W-1:0]  expected_continuations;
    logic [LEN_W-1:0]  write_offset;
  } out_rsp_t;

endpackage

`default_nettype wire

/* sv/hid_message_reassembly.sv */
`default_nettype none

// Channel   Direction  Handshake                Payload
// in_       in         in_valid / in_stall      hmr_pkg::in_req_t  (tick or packet header)
// out_      out        out_valid / out_stall    hmr_pkg::out_rsp_t (one per request)
// cfg_      in         cfg_wr_en (no wait)      timeout_ticks, 32 bits
//
// Each request gives exactly one result, after it passes through the input
// register and then the output register.
// A new request is taken every cycle unless in_stall is high; the transaction
// state closes its loop between the input and output registers.
// Reset (rst_n, synchronous) empties both registers, leaves the block idle
// and loads timeout_ticks with 3000.
// A stall on out_ holds the result; the input register then fills and
// in_stall rises, so at most two requests are held inside.

module hid_message_reassembly #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire hmr_pkg::in_req_t                in_req,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output hmr_pkg::out_rsp_t                    out_rsp,
  input  wire logic                            cfg_wr_en,
  input  wire logic      [hmr_pkg::TICK_W-1:0] cfg_wr_data
);

  logic                        s1_valid_r;
  hmr_pkg::in_req_t            s1_req_r;
  logic                        out_valid_r;
  hmr_pkg::out_rsp_t           out_rsp_r;
  logic [hmr_pkg::TICK_W-1:0]  timeout_r;

  logic                        advance;
  logic [hmr_pkg::CNT_W-1:0]   need;
  hmr_pkg::out_rsp_t           rsp;
  logic                        txn_busy;

  // Move the held request on whenever the output register is free or drains
  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Timeout limit; the user must write it only while idle (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= hmr_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req_r <= in_req;
    end
  end

  // Continuation count from the init length
  hmr_cont_count #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_cont_count (
    .byte_count (s1_req_r.byte_count),
    .need       (need)
  );

  // Transaction tracking and result selection
  hmr_txn_ctrl #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_txn_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .req           (s1_req_r),
    .need          (need),
    .timeout_ticks (timeout_r),
    .rsp           (rsp),
    .txn_busy      (txn_busy)
  );

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= rsp;
    end
  end

`ifndef SYNTHESIS
  a_out_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(advance))
    else $error("result appeared without a request moving on");

  a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && rsp.status == hmr_pkg::ST_STARTED) |=> txn_busy)
    else $error("transaction start did not leave the block busy");

  a_end_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (rsp.status == hmr_pkg::ST_COMPLETE || rsp.status == hmr_pkg::ST_TIMEOUT ||
                 rsp.status == hmr_pkg::ST_INV_CMD || rsp.status == hmr_pkg::ST_INV_SEQ))
    |=> !txn_busy)
    else $error("transaction end left the block busy");

  a_active_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (rsp.status == hmr_pkg::ST_CONTINUED || rsp.status == hmr_pkg::ST_BUSY))
    |-> txn_busy)
    else $error("continuation or busy result while idle");
`endif

endmodule

`default_nettype wire

/* sv/hmr_cont_count.sv */
`default_nettype none

// Continuation packets for a message length: ceil((len - init) / cont),
// zero if the message fits the init payload, saturated to the count width.
// The division is a multiply by a rounded-up reciprocal, exact for every dividend.
module hmr_cont_count #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire logic [hmr_pkg::LEN_W-1:0] byte_count,
  output logic      [hmr_pkg::CNT_W-1:0] need
);

  localparam int unsigned INIT_PAYLOAD = PACKET_BYTES - 7;
  localparam int unsigned CONT_PAYLOAD = PACKET_BYTES - 5;
  // Dividend is rest + cont - 1, one bit wider than a length
  localparam int unsigned NW  = hmr_pkg::LEN_W + 1;
  localparam int unsigned LGC = $clog2(CONT_PAYLOAD);
  localparam int unsigned SH  = NW + LGC;
  localparam int unsigned MW  = NW + 1;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SH) + 64'(CONT_PAYLOAD) - 64'd1) / 64'(CONT_PAYLOAD);
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam int unsigned PW  = NW + MW;
  localparam int unsigned QW  = PW - SH;

  localparam logic [hmr_pkg::LEN_W-1:0] INIT_L = hmr_pkg::LEN_W'(INIT_PAYLOAD);
  localparam logic [NW-1:0] ROUND_UP = NW'(CONT_PAYLOAD - 1);

  logic [hmr_pkg::LEN_W-1:0] rest;
  logic [NW-1:0]             dividend;
  logic [PW-1:0]             prod;
  logic [QW-1:0]             quot;

  always_comb begin
    rest     = byte_count - INIT_L;
    dividend = NW'(rest) + ROUND_UP;
    prod     = PW'(dividend) * PW'(RECIP);
    quot     = prod[PW-1:SH];
    if (byte_count <= INIT_L) begin
      need = '0;
    end else if (32'(quot) > 32'd2047) begin
      need = '1;
    end else begin
      need = hmr_pkg::CNT_W'(quot);
    end
  end

endmodule

`default_nettype wire

/* sv/hmr_txn_ctrl.sv */
`default_nettype none

// Transaction state and the result for the request in the input register.
// State moves only when the request advances into the output register.
module hmr_txn_ctrl #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           advance,
  input  wire hmr_pkg::in_req_t               req,
  input  wire logic      [hmr_pkg::CNT_W-1:0] need,
  input  wire logic      [hmr_pkg::TICK_W-1:0] timeout_ticks,
  output hmr_pkg::out_rsp_t                   rsp,
  output logic                                txn_busy
);

  localparam logic [hmr_pkg::LEN_W-1:0] INIT_PAYLOAD = hmr_pkg::LEN_W'(PACKET_BYTES - 7);
  localparam logic [hmr_pkg::LEN_W-1:0] CONT_PAYLOAD = hmr_pkg::LEN_W'(PACKET_BYTES - 5);

  logic                        busy_r,    busy_nxt;
  logic [hmr_pkg::CHAN_W-1:0]  owner_r,   owner_nxt;
  logic [hmr_pkg::CMD_W-1:0]   cmd_r,     cmd_nxt;
  logic [hmr_pkg::LEN_W-1:0]   len_r,     len_nxt;
  logic [hmr_pkg::CNT_W-1:0]   need_r,    need_nxt;
  logic [hmr_pkg::CNT_W-1:0]   rcvd_r,    rcvd_nxt;
  logic [hmr_pkg::LEN_W-1:0]   offset_r,  offset_nxt;
  logic [hmr_pkg::TICK_W-1:0]  elapsed_r, elapsed_nxt;

  logic [hmr_pkg::CNT_W-1:0]   rcvd_inc;
  logic [hmr_pkg::TICK_W-1:0]  elapsed_inc;
  logic [hmr_pkg::CNT_W-1:0]   seq;
  hmr_pkg::out_rsp_t           saved_rsp;

  assign txn_busy = busy_r;

  always_comb begin
    saved_rsp                        = '0;
    saved_rsp.active_channel         = owner_r;
    saved_rsp.message_command        = cmd_r;
    saved_rsp.message_length         = len_r;
    saved_rsp.expected_continuations = need_r;
  end

  always_comb begin
    rcvd_inc    = rcvd_r + hmr_pkg::CNT_W'(1);
    elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + hmr_pkg::TICK_W'(1);
    seq         = hmr_pkg::CNT_W'(req.cmd_or_seq[hmr_pkg::SEQ_W-1:0]);

    busy_nxt    = busy_r;
    owner_nxt   = owner_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    need_nxt    = need_r;
    rcvd_nxt    = rcvd_r;
    offset_nxt  = offset_r;
    elapsed_nxt = elapsed_r;
    rsp         = '0;
    rsp.status  = hmr_pkg::ST_NONE;

    if (!req.opcode) begin
      if (busy_r) begin
        elapsed_nxt = elapsed_inc;
        if (elapsed_inc > timeout_ticks) begin
          rsp        = saved_rsp;
          rsp.status = hmr_pkg::ST_TIMEOUT;
          busy_nxt   = 1'b0;
        end
      end
    end else if (busy_r) begin
      rsp = saved_rsp;
      if (req.packet_chan != owner_r) begin
        rsp.status = hmr_pkg::ST_BUSY;
      end else if (req.cmd_or_seq[hmr_pkg::INIT_FLAG_BIT]) begin
        rsp.status = hmr_pkg::ST_INV_CMD;
        busy_nxt   = 1'b0;
      end else if (seq != rcvd_r) begin
        rsp.status = hmr_pkg::ST_INV_SEQ;
        busy_nxt   = 1'b0;
      end else begin
        rsp.write_offset = offset_r;
        offset_nxt       = offset_r + CONT_PAYLOAD;
        rcvd_nxt         = rcvd_inc;
        if (rcvd_inc == need_r) begin
          rsp.status = hmr_pkg::ST_COMPLETE;
          busy_nxt   = 1'b0;
        end else begin
          rsp.status = hmr_pkg::ST_CONTINUED;
        end
      end
    end else if (!req.cmd_or_seq[hmr_pkg::INIT_FLAG_BIT]) begin
      rsp.status         = hmr_pkg::ST_INV_CMD;
      rsp.active_channel = req.packet_chan;
    end else begin
      rsp.active_channel  = req.packet_chan;
      rsp.message_command = req.cmd_or_seq;
      rsp.message_length  = req.byte_count;
      if (need == '0) begin
        rsp.status = hmr_pkg::ST_COMPLETE;
      end else begin
        rsp.status                 = hmr_pkg::ST_STARTED;
        rsp.expected_continuations = need;
        busy_nxt    = 1'b1;
        owner_nxt   = req.packet_chan;
        cmd_nxt     = req.cmd_or_seq;
        len_nxt     = req.byte_count;
        need_nxt    = need;
        rcvd_nxt    = '0;
        offset_nxt  = INIT_PAYLOAD;
        elapsed_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rcvd_r    <= '0;
      offset_r  <= '0;
      elapsed_r <= '0;
    end else if (advance) begin
      busy_r    <= busy_nxt;
      rcvd_r    <= rcvd_nxt;
      offset_r  <= offset_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  // Transaction descriptors are reloaded at every start
  always_ff @(posedge clk) begin
    if (advance) begin
      owner_r <= owner_nxt;
      cmd_r   <= cmd_nxt;
      len_r   <= len_nxt;
      need_r  <= need_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/hid_message_reassembly_checker.sv */
`timescale 1ns / 100ps

module hid_message_reassembly_checker #(
  parameter int unsigned PACKET_BYTES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire hmr_pkg::in_req_t           in_req,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire hmr_pkg::out_rsp_t          out_rsp,
  input  wire logic                       cfg_wr_en,
  input  wire logic [hmr_pkg::TICK_W-1:0] cfg_wr_data,
  output int                              fail_count,
  output int                              outstanding
);

  localparam int unsigned INIT_PAY = PACKET_BYTES - 7;
  localparam int unsigned CONT_PAY = PACKET_BYTES - 5;
  localparam int unsigned CNT_MAX  = (1 << hmr_pkg::CNT_W) - 1;

  logic [hmr_pkg::TICK_W-1:0] tick_limit;
  logic                       txn_open;
  logic [hmr_pkg::CHAN_W-1:0] txn_chan;
  logic [hmr_pkg::CMD_W-1:0]  txn_cmd;
  logic [hmr_pkg::LEN_W-1:0]  txn_len;
  logic [hmr_pkg::CNT_W-1:0]  txn_need;
  logic [hmr_pkg::CNT_W-1:0]  txn_got;
  logic [hmr_pkg::LEN_W-1:0]  txn_next_off;
  logic [hmr_pkg::TICK_W-1:0] txn_ticks;

  hmr_pkg::out_rsp_t awaited_rsp[$];
  hmr_pkg::out_rsp_t want;
  int                errors;

  function automatic void close_txn();
    txn_open     = 1'b0;
    txn_chan     = '0;
    txn_cmd      = '0;
    txn_len      = '0;
    txn_need     = '0;
    txn_got      = '0;
    txn_next_off = '0;
    txn_ticks    = '0;
  endfunction

  function automatic hmr_pkg::out_rsp_t txn_result(hmr_pkg::status_t st,
                                                   logic [hmr_pkg::LEN_W-1:0] off);
    hmr_pkg::out_rsp_t r;
    r.status                 = st;
    r.active_channel         = txn_chan;
    r.message_command        = txn_cmd;
    r.message_length         = txn_len;
    r.expected_continuations = txn_need;
    r.write_offset           = off;
    return r;
  endfunction

  // Advance the transaction by one request and give the result it causes
  function automatic hmr_pkg::out_rsp_t reassemble(hmr_pkg::in_req_t q);
    hmr_pkg::out_rsp_t          r;
    int unsigned                need;
    logic [hmr_pkg::LEN_W-1:0]  off;
    logic [hmr_pkg::CNT_W-1:0]  seq_no;
    r      = '0;
    seq_no = hmr_pkg::CNT_W'(q.cmd_or_seq[hmr_pkg::SEQ_W-1:0]);
    if (!q.opcode) begin
      if (txn_open) begin
        if (txn_ticks != '1) txn_ticks++;
        if (txn_ticks > tick_limit) begin
          r = txn_result(hmr_pkg::ST_TIMEOUT, '0);
          close_txn();
        end
      end
    end else if (txn_open) begin
      if (q.packet_chan != txn_chan) begin
        r = txn_result(hmr_pkg::ST_BUSY, '0);
      end else if (q.cmd_or_seq[hmr_pkg::INIT_FLAG_BIT]) begin
        r = txn_result(hmr_pkg::ST_INV_CMD, '0);
        close_txn();
      end else if (seq_no != txn_got) begin
        r = txn_result(hmr_pkg::ST_INV_SEQ, '0);
        close_txn();
      end else begin
        off          = txn_next_off;
        txn_next_off = txn_next_off + hmr_pkg::LEN_W'(CONT_PAY);
        txn_got      = txn_got + hmr_pkg::CNT_W'(1);
        if (txn_got == txn_need) begin
          r = txn_result(hmr_pkg::ST_COMPLETE, off);
          close_txn();
        end else begin
          r = txn_result(hmr_pkg::ST_CONTINUED, off);
        end
      end
    end else if (!q.cmd_or_seq[hmr_pkg::INIT_FLAG_BIT]) begin
      r.status         = hmr_pkg::ST_INV_CMD;
      r.active_channel = q.packet_chan;
    end else begin
      need = 0;
      if (q.byte_count > INIT_PAY) begin
        need = (q.byte_count - INIT_PAY + CONT_PAY - 1) / CONT_PAY;
        if (need > CNT_MAX) need = CNT_MAX;
      end
      if (need == 0) begin
        r.status          = hmr_pkg::ST_COMPLETE;
        r.active_channel  = q.packet_chan;
        r.message_command = q.cmd_or_seq;
        r.message_length  = q.byte_count;
      end else begin
        txn_open     = 1'b1;
        txn_chan     = q.packet_chan;
        txn_cmd      = q.cmd_or_seq;
        txn_len      = q.byte_count;
        txn_need     = hmr_pkg::CNT_W'(need);
        txn_got      = '0;
        txn_next_off = hmr_pkg::LEN_W'(INIT_PAY);
        txn_ticks    = '0;
        r = txn_result(hmr_pkg::ST_STARTED, '0);
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tick_limit = hmr_pkg::TIMEOUT_RESET;
      close_txn();
      awaited_rsp.delete();
    end else begin
      // compare before pushing so an early result cannot match its own request
      if (out_valid && !out_stall) begin
        if (awaited_rsp.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none actual %p", $time, out_rsp);
        end else begin
          want = awaited_rsp.pop_front();
          check_field("status", 32'(want.status), 32'(out_rsp.status));
          check_field("active_channel", want.active_channel, out_rsp.active_channel);
          check_field("message_command", 32'(want.message_command),
                      32'(out_rsp.message_command));
          check_field("message_length", 32'(want.message_length),
                      32'(out_rsp.message_length));
          check_field("expected_continuations", 32'(want.expected_continuations),
                      32'(out_rsp.expected_continuations));
          check_field("write_offset", 32'(want.write_offset), 32'(out_rsp.write_offset));
        end
      end
      if (cfg_wr_en) tick_limit = cfg_wr_data;
      if (in_valid && !in_stall) awaited_rsp.push_back(reassemble(in_req));
    end
    fail_count  <= errors;
    outstanding <= awaited_rsp.size();
  end

endmodule

/* tb/hid_message_reassembly_tb.sv */
`timescale 1ns / 100ps

module hid_message_reassembly_tb;

  localparam int unsigned PACKET_BYTES = 64;
  localparam int unsigned INIT_PAY     = PACKET_BYTES - 7;
  localparam int unsigned CONT_PAY     = PACKET_BYTES - 5;
  localparam int unsigned PHASE_ITEMS  = 310;   // five random phases, about 1550 requests
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned SETTLE       = 8;     // two pipeline registers plus margin

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_stall;
  hmr_pkg::in_req_t           in_req      = '0;
  logic                       out_valid;
  logic                       out_stall   = 1'b0;
  hmr_pkg::out_rsp_t          out_rsp;
  logic                       cfg_wr_en   = 1'b0;
  logic [hmr_pkg::TICK_W-1:0] cfg_wr_data = '0;

  int          fail_count;
  int          outstanding;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  int unsigned long_budget = 0;
  int          stall_run = 0;
  logic        calm = 1'b0;   // when set, neither side idles

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  hid_message_reassembly #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  hid_message_reassembly_checker #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80) return $urandom_range(1, 3);
    if (p < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side in bursts; hold it open while calm
  always @(posedge clk) begin
    if (stall_run > 0) stall_run = stall_run - 1;
    else if (!calm && $urandom_range(0, 3) == 0) stall_run = int'(gap_len());
    out_stall <= (stall_run > 0);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic hmr_pkg::in_req_t mk(logic op, logic [hmr_pkg::CHAN_W-1:0] ch,
                                          logic [hmr_pkg::CMD_W-1:0] cb,
                                          logic [hmr_pkg::LEN_W-1:0] len);
    hmr_pkg::in_req_t r;
    r.opcode      = op;
    r.packet_chan = ch;
    r.cmd_or_seq  = cb;
    r.byte_count  = len;
    return r;
  endfunction

  // Present one request, optionally after an idle gap, and hold it until taken
  task automatic send(hmr_pkg::in_req_t r);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Ticks carry random fields so that every bit toggles while ignored
  task automatic tick_burst(int unsigned n);
    repeat (n) send(mk(1'b0, $urandom, hmr_pkg::CMD_W'($urandom), hmr_pkg::LEN_W'($urandom)));
  endtask

  // Drain the pipeline, then write the timeout while nothing is in flight
  task automatic write_timeout(logic [hmr_pkg::TICK_W-1:0] limit);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [hmr_pkg::CHAN_W-1:0] pick_chan();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 5) return '0;
    if (p < 10) return '1;
    return $urandom;
  endfunction

  // One init packet and its continuations, with ticks, strangers and the
  // odd broken packet mixed in
  task automatic message_episode();
    logic [hmr_pkg::CHAN_W-1:0] ch;
    logic [hmr_pkg::CMD_W-1:0]  cmd;
    logic [hmr_pkg::LEN_W-1:0]  len;
    int unsigned                need;
    int unsigned                p;
    int unsigned                i;
    ch = pick_chan();
    p  = $urandom_range(0, 99);
    if (p < 5) need = 0;
    else if (p < 80) need = $urandom_range(1, 4);
    else if (p < 98 || long_budget == 0) need = $urandom_range(5, 20);
    else begin
      // past 128 continuations the sequence number cannot match any more
      need = $urandom_range(129, 134);
      long_budget--;
    end
    if (need == 0) len = hmr_pkg::LEN_W'($urandom_range(0, INIT_PAY));
    else len = hmr_pkg::LEN_W'(INIT_PAY + CONT_PAY * (need - 1) + $urandom_range(1, CONT_PAY));
    cmd = hmr_pkg::CMD_W'(8'h80 | $urandom_range(0, 127));
    send(mk(1'b1, ch, cmd, len));
    for (i = 0; i < need; i++) begin
      p = $urandom_range(0, 99);
      if (p < 12) tick_burst(1);
      else if (p < 15) tick_burst($urandom_range(1, 60));
      else if (p < 19) send(mk(1'b1, ch ^ (32'h1 << $urandom_range(0, 31)),
                               hmr_pkg::CMD_W'($urandom), hmr_pkg::LEN_W'($urandom)));
      else if (p < 21) begin
        // break the transaction: an init on the owner channel or a bad sequence
        if ($urandom_range(0, 1) == 0)
          send(mk(1'b1, ch, hmr_pkg::CMD_W'(8'h80 | $urandom), hmr_pkg::LEN_W'($urandom)));
        else
          send(mk(1'b1, ch, hmr_pkg::CMD_W'((i + $urandom_range(1, 127)) & 8'h7F),
                  hmr_pkg::LEN_W'($urandom)));
        break;
      end
      send(mk(1'b1, ch, hmr_pkg::CMD_W'(i & 8'h7F), hmr_pkg::LEN_W'($urandom)));
    end
  endtask

  task automatic noise_episode();
    if ($urandom_range(0, 9) == 0) tick_burst($urandom_range(1, 50));
    else send(mk(1'($urandom), pick_chan(), hmr_pkg::CMD_W'($urandom),
                 hmr_pkg::LEN_W'($urandom)));
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned goal;
    goal        = sent + items;
    long_budget = 1;
    while (sent < goal) begin
      if ($urandom_range(0, 99) < 75) message_episode();
      else noise_episode();
      if ($urandom_range(0, 24) == 0) calm <= !calm;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests with the reset timeout
    send(mk(1'b0, 32'h0, 8'h00, 16'h0000));          // tick while idle
    send(mk(1'b0, '1, 8'hFF, 16'hFFFF));              // tick while idle, fields all ones
    send(mk(1'b1, '1, 8'h7F, 16'hFFFF));              // continuation while idle
    send(mk(1'b1, 32'h0, 8'h80, 16'd0));              // empty message
    send(mk(1'b1, 32'h1234_5678, 8'hFF, hmr_pkg::LEN_W'(INIT_PAY))); // fits exactly
    send(mk(1'b1, 32'hCAFE_0001, 8'h81, hmr_pkg::LEN_W'(INIT_PAY + 1))); // one continuation
    send(mk(1'b1, 32'hCAFE_0001, 8'h00, 16'hFFFF));   // last continuation
    send(mk(1'b1, 32'h0000_0055, 8'hC3, hmr_pkg::LEN_W'(INIT_PAY + 2 * CONT_PAY + 1)));
    send(mk(1'b0, 32'h0, 8'h00, 16'h0000));           // tick while active
    send(mk(1'b1, 32'hFFFF_FFAA, 8'h00, 16'h0000));   // packet from a stranger
    send(mk(1'b1, 32'h0000_0055, 8'h00, 16'h1234));
    send(mk(1'b1, 32'h0000_0055, 8'h01, 16'h4321));
    send(mk(1'b1, 32'h0000_0055, 8'h90, 16'h0010));   // init while active
    send(mk(1'b1, '1, 8'hFF, 16'hFFFF));              // longest message
    send(mk(1'b1, '1, 8'h05, 16'h0000));              // wrong sequence

    // Timeout of one: the second tick of a transaction ends it
    write_timeout(32'd1);
    send(mk(1'b1, 32'h0, 8'h80, hmr_pkg::LEN_W'(INIT_PAY + CONT_PAY + 1)));
    send(mk(1'b0, 32'h0, 8'h00, 16'h0000));
    send(mk(1'b0, 32'h0, 8'h00, 16'h0000));
    send(mk(1'b1, 32'h0, 8'h00, 16'h0000));           // lands after the timeout
    send(mk(1'b1, 32'h0, 8'h80, hmr_pkg::LEN_W'(INIT_PAY + 1)));
    send(mk(1'b1, 32'h0, 8'h00, 16'h0000));

    random_phase(PHASE_ITEMS);
    write_timeout(32'd7);
    random_phase(PHASE_ITEMS);
    write_timeout(32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);
    write_timeout(32'd40);
    random_phase(PHASE_ITEMS);
    write_timeout(hmr_pkg::TIMEOUT_RESET);
    random_phase(PHASE_ITEMS);

    // Drain, then wait for any stray result to show up
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
